// ===== rtl/lfa_pkg.sv =====
// Shared types and codes for the lowest-free ID allocator.
package lfa_pkg;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } lfa_state_t;

  typedef struct packed {
    logic load;
    logic inc_widx;
    logic commit;
  } lfa_cmd_t;

  typedef struct packed {
    logic word_done;
    logic slot_free;
  } lfa_sts_t;

endpackage

// ===== rtl/lfa_req_if.sv =====
// Request channel: operation mode and identifier.
interface lfa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] id_in;

  modport source (output valid, output mode, output id_in, input ready);
  modport sink (input valid, input mode, input id_in, output ready);
endinterface

// ===== rtl/lfa_rsp_if.sv =====
// Response channel: allocated identifier and success flag.
interface lfa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] id_out;
  logic       ok;

  modport source (output valid, output id_out, output ok, input ready);
  modport sink (input valid, input id_out, input ok, output ready);
endinterface

// ===== rtl/lfa_datapath.sv =====
// Datapath: used bitmap, word scan, request latch and result register.
module lfa_datapath #(
  parameter int ID_COUNT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  lfa_pkg::lfa_cmd_t cmd,
  output lfa_pkg::lfa_sts_t sts,
  input  logic [1:0]        req_mode,
  input  logic [7:0]        req_id,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output logic [7:0]        rsp_id,
  output logic              rsp_ok
);
  import lfa_pkg::*;

  localparam int POOL_SIZE = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int MAP_WORDS = (POOL_SIZE + 63) / 64;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [63:0]       used_map [MAP_WORDS];
  logic [1:0]        mode;
  logic [7:0]        id;
  logic [WIDX_W-1:0] widx;

  logic              is_alloc;
  logic              id_ok;
  logic [7:0]        id_hi;
  logic [WIDX_W-1:0] id_word;
  logic [WIDX_W-1:0] rd_idx;
  logic [63:0]       word;
  logic              has_free;
  logic [5:0]        free_bit;
  logic [8:0]        cand;
  logic              cand_ok;
  logic              in_use;
  logic              last_word;
  logic [7:0]        res_id;
  logic              res_ok;

  assign is_alloc = (mode == MODE_ALLOC);
  assign id_ok    = ({1'b0, id} < 9'(POOL_SIZE));
  assign id_hi    = id >> 6;
  assign id_word  = id_ok ? id_hi[WIDX_W-1:0] : '0;
  assign rd_idx   = is_alloc ? widx : id_word;
  assign word     = used_map[rd_idx];
  assign has_free = ~&word;

  always_comb begin
    free_bit = '0;
    for (int i = 63; i >= 0; i--) begin
      if (!word[i]) begin
        free_bit = 6'(i);
      end
    end
  end

  assign cand      = (9'(widx) << 6) | {3'b000, free_bit};
  assign cand_ok   = has_free && (cand < 9'(POOL_SIZE));
  assign in_use    = id_ok && word[id[5:0]];
  assign last_word = (widx == WIDX_W'(MAP_WORDS - 1));

  assign sts.word_done = !is_alloc || has_free || last_word;
  assign sts.slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    res_id = '0;
    res_ok = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (cand_ok) begin
          res_id = cand[7:0];
          res_ok = 1'b1;
        end
      end
      MODE_FREE:  res_ok = in_use;
      MODE_QUERY: res_ok = in_use;
      default:    res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= req_mode;
      id   <= req_id;
      widx <= '0;
    end else if (cmd.inc_widx) begin
      widx <= widx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < MAP_WORDS; w++) begin
        used_map[w] <= '0;
      end
    end else if (cmd.commit) begin
      case (mode)
        MODE_ALLOC: begin
          if (cand_ok) begin
            used_map[rd_idx][free_bit] <= 1'b1;
          end
        end
        MODE_FREE: begin
          if (in_use) begin
            used_map[rd_idx][id[5:0]] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_id <= res_id;
      rsp_ok <= res_ok;
    end
  end

endmodule

// ===== rtl/lfa_ctrl.sv =====
// Controller: accepts a request, steps the word scan and commits the result.
module lfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lfa_pkg::lfa_sts_t sts,
  output lfa_pkg::lfa_cmd_t cmd
);
  import lfa_pkg::*;

  lfa_state_t state;
  lfa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (sts.word_done) begin
          if (sts.slot_free) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.inc_widx = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/lowest_free_id_allocator.sv =====
// Lowest-free ID allocator top level.
// Each request allocates the lowest unused ID, frees a given ID or asks whether
// an ID is in use, and gives exactly one response. IDs below min(ID_COUNT, 256)
// are usable; the used bitmap is cleared by reset. An allocate reads one
// 64-bit bitmap word per cycle from the lowest word up and stops at the first
// word with a clear bit or at the last word; at the default ID_COUNT it scans
// 1 to 4 words. The response register lets the next request transfer while a
// response waits; a new response is held back only while the previous one has
// not yet been taken.
module lowest_free_id_allocator #(
  parameter int ID_COUNT = 256
) (
  input logic      clk,
  input logic      rst,
  lfa_req_if.sink  req,
  lfa_rsp_if.source rsp
);
  import lfa_pkg::*;

  lfa_cmd_t cmd;
  lfa_sts_t sts;

  lfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfa_datapath #(
    .ID_COUNT (ID_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_mode  (req.mode),
    .req_id    (req.id_in),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .rsp_id    (rsp.id_out),
    .rsp_ok    (rsp.ok)
  );

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.slot_free)
    else $error("result committed while response register occupied");

  a_fail_zero_id: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ok |-> rsp.id_out == 8'd0)
    else $error("failed response carries nonzero id");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one in progress");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> req.ready)
    else $error("controller did not return to idle after commit");

endmodule

// ===== tb/lowest_free_id_allocator_checker.sv =====
// Checker for the lowest-free ID allocator: predicts each response and compares it.
`timescale 1ns / 1ps
module lowest_free_id_allocator_checker #(
  parameter int ID_COUNT = 256
) (
  input  logic clk,
  input  logic rst,
  lfa_req_if   req,
  lfa_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   refused
);
  import lfa_pkg::*;

  localparam int POOL = (ID_COUNT < 256) ? ID_COUNT : 256;

  typedef struct packed {
    logic [7:0] id_out;
    logic       ok;
  } id_reply_t;

  logic [255:0] busy_ids;
  id_reply_t    reply_q[$];
  int           fails = 0;
  int           seen = 0;
  int           full_hits = 0;

  assign fail_count = fails;
  assign pending    = reply_q.size();
  assign checked    = seen;
  assign refused    = full_hits;

  function automatic id_reply_t serve_request(logic [1:0] op, logic [7:0] id);
    id_reply_t res;
    res = '0;
    case (op)
      MODE_ALLOC: begin
        for (int i = 0; i < POOL; i++) begin
          if (!busy_ids[i]) begin
            busy_ids[i] = 1'b1;
            res.id_out = 8'(i);
            res.ok = 1'b1;
            break;
          end
        end
        if (!res.ok) full_hits++;
      end
      MODE_FREE: begin
        if (int'(id) < POOL && busy_ids[id]) begin
          busy_ids[id] = 1'b0;
          res.ok = 1'b1;
        end
      end
      MODE_QUERY: res.ok = (int'(id) < POOL) && busy_ids[id];
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    id_reply_t want;
    if (rst) begin
      busy_ids = '0;
      reply_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen++;
        if (reply_q.size() == 0) begin
          $error("response with none due: id_out %0d ok %0b", rsp.id_out, rsp.ok);
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (rsp.id_out !== want.id_out) begin
            $error("id_out: expected %0d, actual %0d", want.id_out, rsp.id_out);
            fails++;
          end
          if (rsp.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, rsp.ok);
            fails++;
          end
        end
      end
      if (req.valid && req.ready) reply_q.push_back(serve_request(req.mode, req.id_in));
    end
  end

  final begin
    if (reply_q.size() != 0) $error("%0d responses never arrived", reply_q.size());
  end
endmodule

// ===== tb/lowest_free_id_allocator_tb.sv =====
// Testbench top for the lowest-free ID allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module lowest_free_id_allocator_tb;
  import lfa_pkg::*;

  localparam int ID_COUNT    = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  int   refused;
  int   cycle_count = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   hold_left = 0;
  int   level_est = 0;
  int   sent_by_mode [4] = '{0, 0, 0, 0};

  lfa_req_if req_ch ();
  lfa_rsp_if rsp_ch ();

  lowest_free_id_allocator #(.ID_COUNT(ID_COUNT)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lowest_free_id_allocator_checker #(.ID_COUNT(ID_COUNT)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .refused    (refused)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] id);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= op;
    req_ch.id_in <= id;
    do @(posedge clk); while (!req_ch.ready);
    sent_by_mode[op]++;
    if (op == MODE_ALLOC && level_est < 256) level_est++;
    if (op == MODE_FREE && level_est > 0) level_est--;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned span;
    logic [7:0]  id;
    pick = $urandom_range(99);
    span = (level_est + 8 > 255) ? 255 : level_est + 8;
    if ($urandom_range(3) == 0) id = 8'($urandom_range(255));
    else id = 8'($urandom_range(span));
    if (pick < 40) send_item(MODE_ALLOC, 8'($urandom_range(255)));
    else if (pick < 68) send_item(MODE_FREE, id);
    else if (pick < 93) send_item(MODE_QUERY, id);
    else send_item(MODE_NONE, id);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (count) random_item();
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_ALLOC;
    req_ch.id_in = 8'd0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    send_item(MODE_ALLOC, 8'd255);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_ALLOC, 8'd170);
    send_item(MODE_QUERY, 8'd1);
    send_item(MODE_QUERY, 8'd255);
    send_item(MODE_QUERY, 8'd3);
    send_item(MODE_FREE, 8'd1);
    send_item(MODE_FREE, 8'd1);
    send_item(MODE_QUERY, 8'd1);
    send_item(MODE_ALLOC, 8'd85);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_NONE, 8'd255);
    send_item(MODE_NONE, 8'd0);
    send_item(MODE_FREE, 8'd255);
    send_item(MODE_FREE, 8'd0);
    send_item(MODE_FREE, 8'd2);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_QUERY, 8'd0);
    send_item(MODE_FREE, 8'd128);
    send_item(MODE_QUERY, 8'd170);
    send_item(MODE_QUERY, 8'd85);

    run_phase(0, 0, 180);

    // hold the response side off while requests keep coming, then let it drain
    hold_left = 300;
    run_phase(0, 0, 30);
    drain();

    run_phase(75, 0, 180);
    run_phase(0, 75, 180);
    run_phase(27, 27, 180);

    // fill the pool past full, then punch holes and refill them
    repeat (260) send_item(MODE_ALLOC, 8'($urandom_range(255)));
    send_item(MODE_QUERY, 8'd255);
    send_item(MODE_FREE, 8'd255);
    send_item(MODE_QUERY, 8'd255);
    send_item(MODE_FREE, 8'd100);
    send_item(MODE_FREE, 8'd7);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_ALLOC, 8'd0);
    send_item(MODE_FREE, 8'd255);
    send_item(MODE_QUERY, 8'd127);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("%0d requests: %0d allocates (%0d refused on a full pool), %0d frees,",
             sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3],
             sent_by_mode[0], refused, sent_by_mode[1]);
    $display("%0d queries, %0d no-op modes; %0d responses checked, %0d mismatches",
             sent_by_mode[2], sent_by_mode[3], checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
